/* src/tmc_pkg.sv */
// Shared types, constants and the state relabeling function of the
// Turing machine classifier. No dependencies.
`default_nettype none

package tmc_pkg;

	localparam int TAPE_CELLS_DEF   = 512;
	localparam int WINDOW_COUNT_DEF = 5;
	localparam int LIMIT_COUNT      = 5;
	localparam int LIMIT_W          = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET [LIMIT_COUNT] = '{
		9'd4, 9'd16, 9'd48, 9'd96, 9'd300
	};

	// Verdict codes of a result beat.
	localparam logic [1:0] V_SKIP  = 2'd0;
	localparam logic [1:0] V_HALT  = 2'd1;
	localparam logic [1:0] V_LOOP  = 2'd2;
	localparam logic [1:0] V_UNDEC = 2'd3;

	// Relabelings of states 1..3, new label of state i in bits 2i+1..2i.
	localparam logic [7:0] PERM_TABLE [8] = '{
		8'b11_10_01_00, 8'b11_01_10_00, 8'b10_11_01_00, 8'b01_11_10_00,
		8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_01_00, 8'b11_10_01_00
	};
	localparam logic [2:0] PERM_LAST = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       canon_step;
		logic       run_init;
		logic       win_init;
		logic       win_next;
		logic       copy_rd;
		logic       copy_wr;
		logic       step_rd;
		logic       step_ex;
		logic       step_post;
		logic       step_inc;
		logic       cmp_start;
		logic       cmp_rd;
		logic       cmp_next;
		logic       fin;
		logic [1:0] fin_verdict;
	} tmc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic perm_last;
		logic canonical;
		logic win_done;
		logic at_lim;
		logic copy_last;
		logic edge_hit;
		logic halted;
		logic cond;
		logic mismatch;
		logic cmp_last;
	} tmc_sts_t;

	// Apply one relabeling to a whole machine code.
	function automatic logic [31:0] relabel_code(input logic [31:0] code,
			input logic [2:0] sel);
		logic [7:0] pr;
		logic [3:0] nib;
		logic [1:0] ns;
		logic [1:0] pd;
		logic [31:0] r;
		pr = PERM_TABLE[sel];
		r = '0;
		for (int s = 0; s < 4; s++) begin
			for (int b = 0; b < 2; b++) begin
				nib = code[4*(2*s+b) +: 4];
				ns = pr[2*nib[3:2] +: 2];
				pd = pr[2*s +: 2];
				r[4*(2*pd+b) +: 4] = {ns, nib[1:0]};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/tmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/tmc_ctrl.sv */
// Controller state machine of the classifier: sequences the canonical
// check, the windows, the snapshot copy, the steps and the cycle compare.
// Depends on tmc_pkg.
`default_nettype none

module tmc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	output      logic              done,
	output      tmc_pkg::tmc_cmd_t cmd,
	input  wire tmc_pkg::tmc_sts_t sts
);
	import tmc_pkg::*;

	typedef enum logic [3:0] {
		IDLE, CANON, DECIDE, WIN, COPY_RD, COPY_WR, STEP_CHK,
		STEP_EX, STEP_POST, CMP_RD, CMP_EV
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	assign busy = (state_q != IDLE);
	assign done = done_q;

	// Command decode and next state.
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = CANON;
				end
			end
			CANON: begin
				cmd.canon_step = 1'b1;
				if (sts.perm_last) state_d = DECIDE;
			end
			DECIDE: begin
				if (!sts.canonical) begin
					cmd.fin = 1'b1;
					cmd.fin_verdict = V_SKIP;
					state_d = IDLE;
				end else begin
					cmd.run_init = 1'b1;
					state_d = WIN;
				end
			end
			WIN: begin
				if (sts.win_done) begin
					cmd.fin = 1'b1;
					cmd.fin_verdict = V_UNDEC;
					state_d = IDLE;
				end else begin
					cmd.win_init = 1'b1;
					state_d = COPY_RD;
				end
			end
			COPY_RD: begin
				cmd.copy_rd = 1'b1;
				state_d = COPY_WR;
			end
			COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d = sts.copy_last ? STEP_CHK : COPY_RD;
			end
			STEP_CHK: begin
				if (sts.at_lim) begin
					cmd.win_next = 1'b1;
					state_d = WIN;
				end else begin
					cmd.step_rd = 1'b1;
					state_d = STEP_EX;
				end
			end
			STEP_EX: begin
				if (sts.edge_hit) begin
					cmd.fin = 1'b1;
					cmd.fin_verdict = V_UNDEC;
					state_d = IDLE;
				end else begin
					cmd.step_ex = 1'b1;
					state_d = STEP_POST;
				end
			end
			STEP_POST: begin
				cmd.step_post = 1'b1;
				if (sts.halted) begin
					cmd.fin = 1'b1;
					cmd.fin_verdict = V_HALT;
					state_d = IDLE;
				end else if (sts.cond) begin
					cmd.cmp_start = 1'b1;
					state_d = CMP_RD;
				end else begin
					cmd.step_inc = 1'b1;
					state_d = STEP_CHK;
				end
			end
			CMP_RD: begin
				cmd.cmp_rd = 1'b1;
				state_d = CMP_EV;
			end
			CMP_EV: begin
				if (sts.mismatch) begin
					cmd.step_inc = 1'b1;
					state_d = STEP_CHK;
				end else if (sts.cmp_last) begin
					cmd.fin = 1'b1;
					cmd.fin_verdict = V_LOOP;
					state_d = IDLE;
				end else begin
					cmd.cmp_next = 1'b1;
					state_d = CMP_RD;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// State register and the registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.fin;
		end
	end

endmodule

`default_nettype wire

/* src/tmc_dp.sv */
// Datapath of the classifier: relabeling compare, machine registers,
// tape and snapshot memories and the result registers.
// Depends on tmc_pkg and tmc_ram.
`default_nettype none

module tmc_dp #(
	parameter int TAPE_CELLS   = tmc_pkg::TAPE_CELLS_DEF,
	parameter int WINDOW_COUNT = tmc_pkg::WINDOW_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire tmc_pkg::tmc_cmd_t      cmd,
	output      tmc_pkg::tmc_sts_t      sts,
	input  wire logic [31:0]            machine_code,
	input  wire logic [tmc_pkg::LIMIT_W-1:0] limits [tmc_pkg::LIMIT_COUNT],
	output      logic                   is_canonical,
	output      logic [2:0]             multiplicity,
	output      logic [1:0]             verdict,
	output      logic [8:0]             steps_taken,
	output      logic [9:0]             rightmost_cell
);
	import tmc_pkg::*;

	localparam int PW = $clog2(TAPE_CELLS);
	localparam int WW = $clog2(WINDOW_COUNT + 1);

	logic [31:0]        code_q, least_q, relab;
	logic [2:0]         perm_q, equal_q;
	logic [PW-1:0]      head_q, posmax_q, posmin_q, posright_q, posleft_q;
	logic [PW-1:0]      c_q, kk_q, new_head;
	logic [1:0]         mstate_q, start_q;
	logic [8:0]         step_q, exec_q;
	logic [WW-1:0]      win_q;
	logic               fresh_q;
	logic [LIMIT_W-1:0] lim;
	logic [3:0]         nib;
	logic               tape_rd, snap_rd;
	logic               tape_we, snap_we;
	logic [PW-1:0]      tape_waddr, tape_raddr, snap_raddr;
	logic               tape_wdata;
	logic [2:0]         mult;

	assign relab = relabel_code(code_q, perm_q);
	assign nib = code_q[4*{mstate_q, tape_rd} +: 4];
	assign new_head = nib[0] ? head_q - PW'(1) : head_q + PW'(1);

	// Limit of the current window; windows past the fifth use the last one.
	always_comb begin
		lim = limits[LIMIT_COUNT-1];
		for (int i = 0; i < LIMIT_COUNT - 1; i++) begin
			if (32'(win_q) == i) lim = limits[i];
		end
	end

	// Number of distinct relabelings.
	always_comb begin
		case (equal_q)
			3'd1:    mult = 3'd6;
			3'd2:    mult = 3'd3;
			3'd3:    mult = 3'd2;
			default: mult = 3'd1;
		endcase
	end

	// Status toward the controller.
	always_comb begin
		sts.perm_last = (perm_q == PERM_LAST);
		sts.canonical = (least_q == code_q);
		sts.win_done  = (32'(win_q) == WINDOW_COUNT);
		sts.at_lim    = (step_q >= lim);
		sts.copy_last = (c_q == posleft_q);
		sts.edge_hit  = !nib[0] &&
			({1'b0, head_q} + (PW+1)'(1) >= (PW+1)'(TAPE_CELLS));
		sts.halted    = (head_q == '0);
		sts.cond      = (mstate_q == start_q) &&
			({1'b0, posleft_q} + {1'b0, head_q} ==
			 {1'b0, posmax_q} + {1'b0, posright_q});
		sts.mismatch  = (tape_rd != snap_rd);
		sts.cmp_last  = (kk_q == posleft_q - posmin_q);
	end

	// Memory port selection.
	always_comb begin
		tape_we = 1'b0;
		tape_waddr = head_q;
		tape_wdata = 1'b0;
		if (cmd.run_init) begin
			tape_we = 1'b1;
			tape_waddr = PW'(1);
		end else if (cmd.step_ex) begin
			tape_we = 1'b1;
			tape_wdata = nib[1];
		end else if (cmd.step_post && fresh_q) begin
			tape_we = 1'b1;
		end
		if (cmd.copy_rd) tape_raddr = c_q;
		else if (cmd.cmp_rd) tape_raddr = posmax_q - kk_q;
		else tape_raddr = head_q;
		snap_we = cmd.copy_wr;
		snap_raddr = posleft_q - kk_q;
	end

	tmc_ram #(.WIDTH(1), .DEPTH(TAPE_CELLS)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rd)
	);

	tmc_ram #(.WIDTH(1), .DEPTH(TAPE_CELLS)) u_snap (
		.clk   (clk),
		.we    (snap_we),
		.waddr (c_q),
		.wdata (tape_rd),
		.raddr (snap_raddr),
		.rdata (snap_rd)
	);

	// Machine and run registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= machine_code;
			least_q <= machine_code;
			perm_q <= '0;
			equal_q <= '0;
		end
		if (cmd.canon_step) begin
			if (relab < least_q) least_q <= relab;
			if (relab == code_q) equal_q <= equal_q + 3'd1;
			perm_q <= perm_q + 3'd1;
		end
		if (cmd.run_init) begin
			head_q <= PW'(1);
			mstate_q <= '0;
			step_q <= 9'd1;
			exec_q <= '0;
			posmax_q <= PW'(1);
			win_q <= '0;
		end
		if (cmd.win_init) begin
			posmin_q <= head_q;
			posright_q <= head_q;
			posleft_q <= posmax_q;
			start_q <= mstate_q;
			c_q <= PW'(1);
		end
		if (cmd.win_next) win_q <= win_q + WW'(1);
		if (cmd.copy_wr) c_q <= c_q + PW'(1);
		if (cmd.step_ex) begin
			mstate_q <= nib[3:2];
			head_q <= new_head;
			exec_q <= exec_q + 9'd1;
			fresh_q <= (new_head > posmax_q);
			if (new_head > posmax_q) posmax_q <= new_head;
			if (new_head < posmin_q) posmin_q <= new_head;
		end
		if (cmd.step_inc) step_q <= step_q + 9'd1;
		if (cmd.cmp_start) kk_q <= '0;
		if (cmd.cmp_next) kk_q <= kk_q + PW'(1);
	end

	// Result registers, loaded with the result beat.
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			is_canonical <= (least_q == code_q);
			multiplicity <= mult;
			verdict <= cmd.fin_verdict;
			if (cmd.fin_verdict == V_SKIP) begin
				steps_taken <= '0;
				rightmost_cell <= 10'd1;
			end else begin
				steps_taken <= exec_q;
				rightmost_cell <= 10'(posmax_q);
			end
		end
	end

endmodule

`default_nettype wire

/* src/turing_machine_classifier_top.sv */
// Top level of the 4-state, 2-symbol Turing machine classifier: APB
// register file, controller and datapath. Depends on tmc_pkg, tmc_ctrl, tmc_dp.
`default_nettype none

// A code is taken when start is high and busy is low; its result comes back
// as a single-cycle beat marked by done, which the receiver must take as it
// passes. A code that is not canonical finishes after the relabeling check.
// A canonical code goes on through the windows; at each window start it copies
// the tape up to the rightmost cell so far, then runs machine steps, and
// compares cells whenever the state and head offset match the snapshot. The
// tape memory serves one cell read per cycle.
// No clearing pass: fresh tape cells are zeroed as the head first reaches them.
module turing_machine_classifier_top #(
	parameter int TAPE_CELLS   = tmc_pkg::TAPE_CELLS_DEF,
	parameter int WINDOW_COUNT = tmc_pkg::WINDOW_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [31:0] machine_code,
	output      logic        done,
	output      logic        is_canonical,
	output      logic [2:0]  multiplicity,
	output      logic [1:0]  verdict,
	output      logic [8:0]  steps_taken,
	output      logic [9:0]  rightmost_cell,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import tmc_pkg::*;

	logic [LIMIT_W-1:0] limit_q [LIMIT_COUNT];
	logic [2:0]         reg_idx;
	tmc_cmd_t           cmd;
	tmc_sts_t           sts;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	// Window limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			for (int i = 0; i < LIMIT_COUNT; i++) begin
				if (32'(reg_idx) == i) limit_q[i] <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	// Register read back.
	always_comb begin
		prdata = '0;
		for (int i = 0; i < LIMIT_COUNT; i++) begin
			if (32'(reg_idx) == i) prdata = 32'(limit_q[i]);
		end
	end

	tmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	tmc_dp #(.TAPE_CELLS(TAPE_CELLS), .WINDOW_COUNT(WINDOW_COUNT)) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.sts            (sts),
		.machine_code   (machine_code),
		.limits         (limit_q),
		.is_canonical   (is_canonical),
		.multiplicity   (multiplicity),
		.verdict        (verdict),
		.steps_taken    (steps_taken),
		.rightmost_cell (rightmost_cell)
	);

`ifndef SYNTH
	// A result beat only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a code in work");

	// A code is skipped exactly when it is not canonical.
	a_skip_canon: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((verdict == V_SKIP) == !is_canonical))
		else $error("skip verdict disagrees with canonical flag");

	// Multiplicity is a divisor of six.
	a_mult: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (multiplicity == 3'd1 || multiplicity == 3'd2 ||
			multiplicity == 3'd3 || multiplicity == 3'd6))
		else $error("bad multiplicity");
`endif

endmodule

`default_nettype wire
